// File: hw/rtl/b10k_pkg.sv
package b10k_pkg;

	// Input item kinds (s_tuser)
	localparam logic [1:0] FUNC_DIGIT   = 2'd0;
	localparam logic [1:0] FUNC_NULL    = 2'd1;
	localparam logic [1:0] FUNC_NODIGIT = 2'd2;
	localparam logic [1:0] FUNC_CORRUPT = 2'd3;

	// Result status codes (m_tuser)
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NULL    = 2'd1;
	localparam logic [1:0] STAT_RANGE   = 2'd2;
	localparam logic [1:0] STAT_CORRUPT = 2'd3;

	localparam int DIGIT_W  = 14;
	localparam int WEIGHT_W = 16;
	localparam int SCALE_W  = 16;
	localparam int VALUE_W  = 128;
	localparam int CNT_W    = 16;
	// Working scale: 4 * (count - weight - 1) before stripping fits 21 signed bits
	localparam int WSCALE_W = 21;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Byte-wise divide by ten: q = (t * RECIP_10) >> 16 is exact for t < 2560
	localparam logic [12:0] RECIP_10 = 13'd6554;

	// Multiply-by-ten steps per base-10000 digit
	localparam logic [1:0] LAST_MUL_STEP = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef enum logic {
		OP_MUL10,
		OP_DIV10
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		logic    add_digit;
	} alu_ctrl_t;

endpackage

// File: hw/rtl/b10k_alu.sv
// Shared arithmetic unit: one multiply-by-ten step with overflow detect,
// or one byte of a long division by ten.
module b10k_alu #(
	parameter int MAG_W = 127,
	parameter int DW    = 128
) (
	input  b10k_pkg::alu_ctrl_t           ctrl,
	input  logic [MAG_W-1:0]              mag,
	input  logic [b10k_pkg::DIGIT_W-1:0]  digit,
	input  logic [DW-1:0]                 work,
	input  logic [3:0]                    rem,
	output logic [DW-1:0]                 res,
	output logic                          flag,
	output logic [3:0]                    rem_nxt
);
	import b10k_pkg::*;

	logic [MAG_W+3:0] mul_wide;
	logic [MAG_W+3:0] addend;
	logic [11:0]      div_t;
	logic [24:0]      div_prod;
	logic [7:0]       div_q;
	logic [11:0]      div_back;
	logic [DW-1:0]    div_work;

	// mag * 10 + addend, checked against the magnitude width
	assign addend   = ctrl.add_digit ? (MAG_W+4)'(digit) : '0;
	assign mul_wide = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + addend;

	// Divide the top byte with the running remainder
	assign div_t    = {rem, work[DW-1 -: 8]};
	assign div_prod = 25'(div_t) * 25'(RECIP_10);
	assign div_q    = div_prod[23:16];
	assign div_back = div_t - 12'(div_q) * 12'd10;
	assign div_work = {work[DW-9:0], div_q};

	// Select the result for the active operation
	always_comb begin
		case (ctrl.op)
			OP_MUL10: begin
				res     = DW'(mul_wide[MAG_W-1:0]);
				flag    = |mul_wide[MAG_W+3:MAG_W];
				rem_nxt = '0;
			end
			OP_DIV10: begin
				res     = div_work;
				flag    = 1'b0;
				rem_nxt = div_back[3:0];
			end
			default: begin
				res     = '0;
				flag    = 1'b0;
				rem_nxt = '0;
			end
		endcase
	end

endmodule

// File: hw/rtl/base10000_digits_to_decimal128.sv
// Converts the base-10000 digits of a database numeric, most significant
// first, into a signed 128-bit value and a signed 16-bit decimal scale.
// Input kind is s_tuser (digit, null, no digits, corrupted header); the last
// digit is marked by s_tlast and carries sign and header weight. One result
// comes out per last digit and per non-digit item, with status on m_tuser.
// Sequence: a non-digit item goes from idle to the emit state and on to the
// output register. A digit is accepted and then makes four multiply-by-ten
// passes through the shared unit. After a last digit, a check state sends a
// zero or out-of-range value straight to emit; a nonzero value is divided by
// ten byte-serially in the same unit, one pass of ceil((ACC_BITS-1)/8) bytes
// per stripped trailing zero plus a final pass, then a finish state. Digits
// arriving after overflow are accepted without a multiply pass. s_tready is
// high only while the unit is idle; one finished result may wait in the
// output register while the next item is processed.
module base10000_digits_to_decimal128 #(
	parameter int ACC_BITS = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // digit[13:0], negative[14], header_weight[30:15], zero[31]
	input  logic [1:0]   s_tuser,   // func[1:0]
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // value_high[63:0], value_low[127:64], scale[143:128]
	output logic [1:0]   m_tuser    // status[1:0]
);
	import b10k_pkg::*;

	localparam int MAG_W  = ACC_BITS - 1;
	localparam int NCHUNK = (MAG_W + 7) / 8;
	localparam int DW     = NCHUNK * 8;
	localparam int CHW    = $clog2(NCHUNK);
	localparam logic [CHW-1:0] LAST_CHUNK = CHW'(NCHUNK - 1);

	state_t state_q, state_nxt;

	logic [MAG_W-1:0]         mag_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     ovf_q;
	logic [1:0]               step_q;
	logic [CHW-1:0]           chunk_q;
	logic [DW-1:0]            work_q;
	logic [3:0]               rem_q;
	logic signed [WSCALE_W-1:0] scale_q;

	logic [DIGIT_W-1:0]       digit_q;
	logic                     last_q;
	logic                     neg_q;
	logic signed [WEIGHT_W-1:0] weight_q;

	logic [1:0]               res_status_q;
	logic [VALUE_W-1:0]       res_val_q;
	logic [SCALE_W-1:0]       res_scale_q;

	logic                     m_tvalid_q;
	logic [143:0]             m_tdata_q;
	logic [1:0]               m_tuser_q;

	alu_ctrl_t                alu_ctrl;
	logic [DW-1:0]            alu_res;
	logic                     alu_flag;
	logic [3:0]               alu_rem;

	logic                     in_acc;
	logic                     emit_go;
	logic                     cnt_full;
	logic                     scale_bad;
	logic [VALUE_W-1:0]       mag_ext;
	logic signed [WSCALE_W-1:0] scale_init;

	assign in_acc   = s_tvalid && s_tready;
	assign cnt_full = (cnt_q == CNT_MAX);
	assign mag_ext  = VALUE_W'(mag_q);
	assign scale_bad = (scale_q < -WSCALE_W'(32768)) || (scale_q > WSCALE_W'(32767));
	assign scale_init = (WSCALE_W'(signed'({1'b0, cnt_q})) - WSCALE_W'(weight_q)
		- WSCALE_W'(1)) <<< 2;

	b10k_alu #(
		.MAG_W(MAG_W),
		.DW   (DW)
	) u_alu (
		.ctrl   (alu_ctrl),
		.mag    (mag_q),
		.digit  (digit_q),
		.work   (work_q),
		.rem    (rem_q),
		.res    (alu_res),
		.flag   (alu_flag),
		.rem_nxt(alu_rem)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser != FUNC_DIGIT)
						state_nxt = ST_EMIT;
					else if (ovf_q || cnt_full)
						state_nxt = s_tlast ? ST_CHECK : ST_IDLE;
					else
						state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				if (step_q == LAST_MUL_STEP)
					state_nxt = last_q ? ST_CHECK : ST_IDLE;
			end
			ST_CHECK: begin
				if (ovf_q || mag_q == '0)
					state_nxt = ST_EMIT;
				else
					state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (chunk_q == LAST_CHUNK && alu_rem != 4'd0)
					state_nxt = ST_FIN;
			end
			ST_FIN:  state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (emit_go)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_tready           = (state_q == ST_IDLE);
		alu_ctrl.op        = (state_q == ST_DIV) ? OP_DIV10 : OP_MUL10;
		alu_ctrl.add_digit = (step_q == LAST_MUL_STEP);
		emit_go            = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	end

	// Control and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mag_q      <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			step_q     <= '0;
			chunk_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_acc) begin
						if (s_tuser != FUNC_DIGIT) begin
							mag_q <= '0;
							cnt_q <= '0;
							ovf_q <= 1'b0;
						end else if (!ovf_q && cnt_full) begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_MUL: begin
					mag_q  <= alu_res[MAG_W-1:0];
					ovf_q  <= ovf_q | alu_flag;
					step_q <= step_q + 2'd1;
					if (step_q == LAST_MUL_STEP && !(ovf_q || alu_flag))
						cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_CHECK: chunk_q <= '0;
				ST_DIV: begin
					if (chunk_q == LAST_CHUNK) begin
						chunk_q <= '0;
						if (alu_rem == 4'd0)
							mag_q <= alu_res[MAG_W-1:0];
					end else begin
						chunk_q <= chunk_q + CHW'(1);
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						mag_q <= '0;
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: ;
			endcase
			// Output register handshake
			if (emit_go)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					digit_q     <= s_tdata[13:0];
					neg_q       <= s_tdata[14];
					weight_q    <= s_tdata[30:15];
					last_q      <= s_tlast;
					res_val_q   <= '0;
					res_scale_q <= '0;
					case (s_tuser)
						FUNC_NULL:    res_status_q <= STAT_NULL;
						FUNC_CORRUPT: res_status_q <= STAT_CORRUPT;
						default:      res_status_q <= STAT_OK;
					endcase
				end
			end
			ST_CHECK: begin
				res_status_q <= ovf_q ? STAT_RANGE : STAT_OK;
				res_val_q    <= '0;
				res_scale_q  <= '0;
				scale_q      <= scale_init;
				work_q       <= DW'(mag_q);
				rem_q        <= '0;
			end
			ST_DIV: begin
				work_q <= alu_res;
				if (chunk_q == LAST_CHUNK) begin
					rem_q <= '0;
					if (alu_rem == 4'd0)
						scale_q <= scale_q - WSCALE_W'(1);
				end else begin
					rem_q <= alu_rem;
				end
			end
			ST_FIN: begin
				// Apply the sign, or report a scale outside 16 bits
				if (scale_bad) begin
					res_status_q <= STAT_RANGE;
					res_val_q    <= '0;
					res_scale_q  <= '0;
				end else begin
					res_status_q <= STAT_OK;
					res_val_q    <= neg_q ? (VALUE_W'(0) - mag_ext) : mag_ext;
					res_scale_q  <= scale_q[SCALE_W-1:0];
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					m_tdata_q <= {res_scale_q, res_val_q[63:0], res_val_q[127:64]};
					m_tuser_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: hw/rtl/b10k_chk.sv
module b10k_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [31:0]  s_tdata,
	input logic [1:0]   s_tuser,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata,
	input logic [1:0]   m_tuser
);
	import b10k_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// A non-digit item always produces a result, so the input side stalls
	a_nondigit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != FUNC_DIGIT |=> !s_tready)
		else $error("input taken while non-digit result pending");

	// Any failing status carries a zero payload
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0)
		else $error("nonzero payload on failing status");

	// A zero value always has scale zero
	a_zero_scale: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_OK && m_tdata[127:0] == '0 |-> m_tdata[143:128] == '0)
		else $error("zero value with nonzero scale");

endmodule

bind base10000_digits_to_decimal128 b10k_chk u_b10k_chk (.*);

// File: bench/tb_base10000_digits_to_decimal128.sv
`timescale 1ns / 100ps

import b10k_pkg::*;

// One converted number as it leaves the block
typedef struct {
	logic [1:0]  status;
	logic [63:0] value_high;
	logic [63:0] value_low;
	logic [15:0] scale;
} decimal_t;

class decimal_scoreboard;
	logic [127:0] magnitude;
	logic [15:0]  digit_count;
	bit           overflowed;
	decimal_t     expected_decimals[$];
	int           errors;

	function new();
		magnitude   = '0;
		digit_count = '0;
		overflowed  = 1'b0;
		errors      = 0;
	endfunction

	function int pending();
		return expected_decimals.size();
	endfunction

	// Queue one result and start a fresh number
	function void push_decimal(logic [1:0] status, logic [127:0] value, logic [15:0] scale);
		decimal_t d;
		d.status     = status;
		d.value_high = value[127:64];
		d.value_low  = value[63:0];
		d.scale      = scale;
		expected_decimals.push_back(d);
		magnitude   = '0;
		digit_count = '0;
		overflowed  = 1'b0;
	endfunction

	// Advance the conversion by one accepted input item
	function void accumulate_item(logic [1:0] func, logic [13:0] digit, logic last, logic neg,
			logic signed [15:0] weight);
		logic [143:0] product;
		logic [127:0] value;
		longint       scale;
		case (func)
			FUNC_NULL:    push_decimal(STAT_NULL, '0, '0);
			FUNC_NODIGIT: push_decimal(STAT_OK, '0, '0);
			FUNC_CORRUPT: push_decimal(STAT_CORRUPT, '0, '0);
			default: begin
				// accumulate, stick at overflow of magnitude or digit count
				if (!overflowed) begin
					if (digit_count == CNT_MAX) begin
						overflowed = 1'b1;
					end else begin
						product = {16'd0, magnitude} * 144'd10000 + {130'd0, digit};
						if (product[143:127] != '0) begin
							overflowed = 1'b1;
						end else begin
							magnitude   = product[127:0];
							digit_count = digit_count + 16'd1;
						end
					end
				end
				if (last) begin
					if (overflowed) begin
						push_decimal(STAT_RANGE, '0, '0);
					end else if (magnitude == '0) begin
						push_decimal(STAT_OK, '0, '0);
					end else begin
						value = magnitude;
						scale = 4 * (longint'(digit_count) - longint'(weight) - 1);
						// strip trailing decimal zeros
						while (value % 10 == 0) begin
							value = value / 10;
							scale--;
						end
						if (scale < -32768 || scale > 32767)
							push_decimal(STAT_RANGE, '0, '0);
						else
							push_decimal(STAT_OK, neg ? -value : value, scale[15:0]);
					end
				end
			end
		endcase
	endfunction

	task report_mismatch(string what, logic [127:0] got, logic [127:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	// Compare one delivered result with the oldest expected one
	task check_decimal(logic [1:0] status, logic [143:0] data);
		decimal_t want;
		if (expected_decimals.size() == 0) begin
			report_mismatch("status of unexpected result", {126'd0, status}, '0);
			return;
		end
		want = expected_decimals.pop_front();
		if (status !== want.status)
			report_mismatch("status", {126'd0, status}, {126'd0, want.status});
		if (data[63:0] !== want.value_high)
			report_mismatch("value_high", {64'd0, data[63:0]}, {64'd0, want.value_high});
		if (data[127:64] !== want.value_low)
			report_mismatch("value_low", {64'd0, data[127:64]}, {64'd0, want.value_low});
		if (data[143:128] !== want.scale)
			report_mismatch("scale", {112'd0, data[143:128]}, {112'd0, want.scale});
	endtask
endclass

module tb_base10000_digits_to_decimal128;

	localparam int CYCLE_LIMIT  = 6_000_000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int DRAIN_CYCLES = 700;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata  = '0;
	logic [1:0]   s_tuser  = FUNC_DIGIT;
	logic         s_tlast  = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic [1:0]   m_tuser;

	decimal_scoreboard sb = new();

	int          src_idle_pct   = 0;
	int          sink_stall_pct = 0;
	int          items_sent     = 0;
	int unsigned cycle_count    = 0;
	logic [13:0] digit_q[$];

	base10000_digits_to_decimal128 #(.ACC_BITS(128)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Sample both handshakes with pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_decimal(m_tuser, m_tdata);
			if (s_tvalid && s_tready)
				sb.accumulate_item(s_tuser, s_tdata[13:0], s_tlast, s_tdata[14], s_tdata[30:15]);
		end
	end

	// Stall the result side in random bursts
	initial begin
		forever begin
			@(posedge clk);
			if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Offer one item, with an optional idle burst ahead of it
	task automatic send_item(input logic [1:0] func, input logic [13:0] digit, input logic last,
			input logic neg, input logic [15:0] weight);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tlast  <= last;
		s_tdata  <= {1'b0, weight, neg, digit};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Non-digit item; its unused fields carry noise
	task automatic send_marker(input logic [1:0] func);
		send_item(func, 14'($urandom_range(0, 16383)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
	endtask

	// Send digit_q as one number, sign and weight on the last digit
	task automatic send_number(input logic neg, input logic [15:0] weight);
		for (int i = 0; i < digit_q.size(); i++) begin
			if (i == digit_q.size() - 1)
				send_item(FUNC_DIGIT, digit_q[i], 1'b1, neg, weight);
			else
				send_item(FUNC_DIGIT, digit_q[i], 1'b0, 1'($urandom_range(0, 1)),
					16'($urandom_range(0, 65535)));
		end
		digit_q.delete();
	endtask

	// Hold the sender until every expected result has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic send_random_number();
		int ndig;
		int sel;
		int w;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			ndig = $urandom_range(1, 4);
		else if (sel < 85)
			ndig = $urandom_range(5, 9);
		else
			ndig = $urandom_range(10, 12);
		for (int i = 0; i < ndig; i++) begin
			sel = $urandom_range(0, 99);
			// ten-digit numbers often start low enough to stay near the top of range
			if (i == 0 && ndig == 10 && sel < 50)
				digit_q.push_back(14'($urandom_range(0, 171)));
			else if (sel < 65)
				digit_q.push_back(14'($urandom_range(0, 9999)));
			else if (sel < 82)
				digit_q.push_back(14'd0);
			else if (sel < 90)
				digit_q.push_back(14'($urandom_range(1, 999) * 10));
			else if (sel < 96)
				digit_q.push_back(14'($urandom_range(1, 9) * 1000));
			else
				digit_q.push_back(14'($urandom_range(10000, 16383)));
		end
		if ($urandom_range(0, 3) == 0)
			w = $urandom_range(0, 65535);
		else
			w = ndig + 2 - $urandom_range(0, 12);
		send_number(1'($urandom_range(0, 1)), w[15:0]);
	endtask

	initial begin
		int base;
		int progress;
		int phase;
		int next_phase;
		int sel;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items
		src_idle_pct   = 20;
		sink_stall_pct = 15;
		send_marker(FUNC_NULL);
		send_marker(FUNC_NODIGIT);
		send_marker(FUNC_CORRUPT);
		// negative zero loses its sign
		digit_q = '{0};
		send_number(1'b1, 16'h7FFF);
		// widest digit field, above 9999
		digit_q = '{16383};
		send_number(1'b1, 16'hFFFF);
		digit_q = '{9999};
		send_number(1'b0, 16'h0000);
		// largest magnitude, negated
		digit_q = '{170, 1411, 8346, 469, 2317, 3168, 7303, 7158, 8410, 5727};
		send_number(1'b1, 16'd9);
		// one past the largest overflows; later digits change nothing
		digit_q = '{170, 1411, 8346, 469, 2317, 3168, 7303, 7158, 8410, 5728, 3, 9999};
		send_number(1'b0, 16'd9);
		// ten to the 38th, every zero stripped
		digit_q = '{100, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_number(1'b1, 16'd9);
		// scale at and just past both 16-bit limits
		digit_q = '{10};
		send_number(1'b0, -16'sd8192);
		digit_q = '{7};
		send_number(1'b1, -16'sd8192);
		digit_q = '{7};
		send_number(1'b0, 16'sd8192);
		digit_q = '{70};
		send_number(1'b1, 16'sd8192);
		digit_q = '{1};
		send_number(1'b0, 16'h8000);
		digit_q = '{5};
		send_number(1'b1, 16'h7FFF);
		// partial numbers dropped by each marker kind
		send_item(FUNC_DIGIT, 14'd12, 1'b0, 1'b1, 16'd3);
		send_marker(FUNC_NULL);
		send_item(FUNC_DIGIT, 14'd9999, 1'b0, 1'b0, 16'd0);
		send_marker(FUNC_NODIGIT);
		send_item(FUNC_DIGIT, 14'd77, 1'b0, 1'b0, 16'd0);
		send_marker(FUNC_CORRUPT);
		digit_q = '{5};
		send_number(1'b0, 16'd0);
		wait_drained();

		// Random items: mostly whole numbers, some cut short, some lone markers
		base  = items_sent;
		phase = 0;
		while (items_sent - base < RANDOM_ITEMS) begin
			progress = items_sent - base;
			if (progress < 500)
				next_phase = 0;
			else if (progress < 900)
				next_phase = 1;
			else if (progress < 1400)
				next_phase = 2;
			else
				next_phase = 3;
			if (next_phase != phase) begin
				wait_drained();
				phase = next_phase;
			end
			case (phase)
				0: begin
					src_idle_pct   = 25;
					sink_stall_pct = 10;
				end
				2: begin
					src_idle_pct   = 50;
					sink_stall_pct = 30;
				end
				default: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
			endcase
			sel = $urandom_range(0, 99);
			if (sel < 75) begin
				send_random_number();
			end else if (sel < 90) begin
				repeat ($urandom_range(1, 4))
					send_item(FUNC_DIGIT, 14'($urandom_range(0, 9999)), 1'b0,
						1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
				send_marker(2'($urandom_range(FUNC_NULL, FUNC_CORRUPT)));
			end else begin
				send_marker(2'($urandom_range(FUNC_NULL, FUNC_CORRUPT)));
			end
		end

		// Drain and let any stray output show up
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
